FILE: hw/rtl/sbpp_pkg.sv
package sbpp_pkg;

  localparam int unsigned SBPP_PARAM_DEPTH = 32;

  localparam logic [7:0] START_BYTE   = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;

  localparam logic [7:0] OP_PING      = 8'h01;
  localparam logic [7:0] OP_READ      = 8'h02;
  localparam logic [7:0] OP_WRITE     = 8'h03;
  localparam logic [7:0] OP_REG_WRITE = 8'h04;
  localparam logic [7:0] OP_ACTION    = 8'h05;
  localparam logic [7:0] OP_RESET     = 8'h06;

  localparam int unsigned REG_ADDR_W = 4;
  localparam logic [1:0] REG_OWN_ID    = 2'd0;
  localparam logic [1:0] REG_REPLY_OP  = 2'd1;
  localparam logic [1:0] REG_CALIB_OP  = 2'd2;

  localparam logic [7:0] RST_OWN_ID   = 8'd1;
  localparam logic [7:0] RST_REPLY_OP = 8'd0;
  localparam logic [7:0] RST_CALIB_OP = 8'd7;

  typedef enum logic [2:0] {
    CMD_PING      = 3'd0,
    CMD_ACTION    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_REG_WRITE = 3'd4,
    CMD_RESET     = 3'd5,
    CMD_CALIBRATE = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [7:0] own_id;
    logic [7:0] reply_op;
    logic [7:0] calib_op;
  } cfg_t;

  typedef struct packed {
    logic load_id;
    logic load_len;
    logic load_instr;
    logic store_param;
    logic emit_hdr;
    logic emit_next;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic id_ok;
    logic no_params;
    logic is_reply;
    logic too_long;
    logic param_done;
    logic frame_ok;
    logic has_params;
    logic emit_last;
    logic out_valid;
    logic out_free;
  } dp_status_t;

  function automatic logic is_parameterless(input logic [7:0] op, input logic [7:0] calib);
    return (op == OP_PING) || (op == OP_ACTION) || (op == OP_RESET) || (op == calib);
  endfunction

  function automatic cmd_e classify(input logic [7:0] op, input logic [7:0] calib);
    cmd_e c;
    case (op)
      OP_PING:      c = CMD_PING;
      OP_ACTION:    c = CMD_ACTION;
      OP_READ:      c = CMD_READ;
      OP_WRITE:     c = CMD_WRITE;
      OP_REG_WRITE: c = CMD_REG_WRITE;
      OP_RESET:     c = CMD_RESET;
      default:      c = (op == calib) ? CMD_CALIBRATE : CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/servo_bus_packet_parser.sv
// a command result becomes valid in the cycle after the checksum byte transfer
// parameter results follow one per cycle from the registered parameter store read port while the output does not stall
// one byte is taken per cycle while parsing, unless the checksum byte waits on a pending result;
// after a good packet with parameters the input stalls while the parameter results go out
// reset: rst_ni is asynchronous active low, resets parse state, output valid and config registers
module servo_bus_packet_parser #(
  parameter int unsigned PARAM_DEPTH = sbpp_pkg::SBPP_PARAM_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            result_kind_o,
  output logic [2:0]                      command_o,
  output logic                            addressed_to_self_o,
  output logic                            send_reply_o,
  output logic [5:0]                      param_count_o,
  output logic [7:0]                      param_byte_o,
  output logic                            last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbpp_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  sbpp_pkg::cfg_t       cfg;
  sbpp_pkg::dp_cmd_t    dp_cmd;
  sbpp_pkg::dp_status_t dp_status;

  sbpp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  sbpp_dp #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .rx_byte_i           (rx_byte_i),
    .cfg_i               (cfg),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_kind_o       (result_kind_o),
    .command_o           (command_o),
    .addressed_to_self_o (addressed_to_self_o),
    .send_reply_o        (send_reply_o),
    .param_count_o       (param_count_o),
    .param_byte_o        (param_byte_o),
    .last_o              (last_o)
  );

endmodule

FILE: hw/rtl/sbpp_ram.sv
module sbpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sbpp_regs.sv
module sbpp_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbpp_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output sbpp_pkg::cfg_t                      cfg_o
);

  sbpp_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        sbpp_pkg::REG_OWN_ID:   cfg_d.own_id   = pwdata[7:0];
        sbpp_pkg::REG_REPLY_OP: cfg_d.reply_op = pwdata[7:0];
        sbpp_pkg::REG_CALIB_OP: cfg_d.calib_op = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id   <= sbpp_pkg::RST_OWN_ID;
      cfg_q.reply_op <= sbpp_pkg::RST_REPLY_OP;
      cfg_q.calib_op <= sbpp_pkg::RST_CALIB_OP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      sbpp_pkg::REG_OWN_ID:   prdata = {24'd0, cfg_q.own_id};
      sbpp_pkg::REG_REPLY_OP: prdata = {24'd0, cfg_q.reply_op};
      sbpp_pkg::REG_CALIB_OP: prdata = {24'd0, cfg_q.calib_op};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/sbpp_ctrl.sv
module sbpp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sbpp_pkg::dp_status_t status_i,
  output sbpp_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_START1 = 8'b0000_0001,
    S_START2 = 8'b0000_0010,
    S_ID     = 8'b0000_0100,
    S_LEN    = 8'b0000_1000,
    S_INSTR  = 8'b0001_0000,
    S_PARAM  = 8'b0010_0000,
    S_CSUM   = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q == S_EMIT) || ((state_q == S_CSUM) && status_i.out_valid);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_START1: begin
        if (accept) begin
          state_d = status_i.is_start ? S_START2 : S_START1;
        end
      end
      S_START2: begin
        if (accept) begin
          state_d = status_i.is_start ? S_ID : S_START1;
        end
      end
      S_ID: begin
        if (accept) begin
          cmd_o.load_id = status_i.id_ok;
          state_d       = status_i.id_ok ? S_LEN : S_START1;
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd_o.load_len = 1'b1;
          state_d        = S_INSTR;
        end
      end
      S_INSTR: begin
        if (accept) begin
          cmd_o.load_instr = 1'b1;
          if (status_i.no_params) begin
            state_d = S_CSUM;
          end else if (status_i.is_reply || status_i.too_long) begin
            state_d = S_START1;
          end else begin
            state_d = S_PARAM;
          end
        end
      end
      S_PARAM: begin
        if (accept) begin
          cmd_o.store_param = 1'b1;
          if (status_i.param_done) begin
            state_d = S_CSUM;
          end
        end
      end
      S_CSUM: begin
        if (accept) begin
          cmd_o.emit_hdr = status_i.frame_ok;
          state_d = (status_i.frame_ok && status_i.has_params) ? S_EMIT : S_START1;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_next = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_START1;
          end
        end
      end
      default: state_d = S_START1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/sbpp_dp.sv
module sbpp_dp #(
  parameter int unsigned PARAM_DEPTH = sbpp_pkg::SBPP_PARAM_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           rx_byte_i,
  input  sbpp_pkg::cfg_t       cfg_i,
  input  sbpp_pkg::dp_cmd_t    cmd_i,
  output sbpp_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 result_kind_o,
  output logic [2:0]           command_o,
  output logic                 addressed_to_self_o,
  output logic                 send_reply_o,
  output logic [5:0]           param_count_o,
  output logic [7:0]           param_byte_o,
  output logic                 last_o
);

  localparam int unsigned AW    = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(PARAM_DEPTH + 1);

  logic [7:0]       target_q, len_q, instr_q, sum_q;
  logic [CNT_W-1:0] idx_q, rd_idx_q, rd_idx_next;
  logic [AW-1:0]    rd_addr_next;

  logic             out_valid_q, out_kind_q, out_self_q, out_reply_q, out_last_q;
  sbpp_pkg::cmd_e   out_cmd_q;
  logic [CNT_W-1:0] out_count_q;
  logic [7:0]       out_byte_q;

  sbpp_pkg::cmd_e   cmd_cls;
  logic [CNT_W-1:0] count_d;
  logic             self_d, reply_d;
  logic [8:0]       idx_plus3;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  assign cmd_cls   = sbpp_pkg::classify(instr_q, cfg_i.calib_op);
  assign count_d   = ((cmd_cls == sbpp_pkg::CMD_READ) || (cmd_cls == sbpp_pkg::CMD_WRITE) ||
                      (cmd_cls == sbpp_pkg::CMD_REG_WRITE)) ? idx_q : '0;
  assign self_d    = (target_q == cfg_i.own_id);
  assign reply_d   = self_d && ((cmd_cls == sbpp_pkg::CMD_PING) ||
                                (cmd_cls == sbpp_pkg::CMD_REG_WRITE) ||
                                (cmd_cls == sbpp_pkg::CMD_RESET));
  assign idx_plus3 = 9'(idx_q) + 9'd3;

  assign rd_idx_next  = rd_idx_q + 1'b1;
  assign rd_addr_next = rd_idx_next[AW-1:0];

  always_comb begin
    status_o.is_start   = (rx_byte_i == sbpp_pkg::START_BYTE);
    status_o.id_ok      = (rx_byte_i == cfg_i.own_id) || (rx_byte_i == sbpp_pkg::BROADCAST_ID);
    status_o.no_params  = sbpp_pkg::is_parameterless(rx_byte_i, cfg_i.calib_op);
    status_o.is_reply   = (rx_byte_i == cfg_i.reply_op);
    status_o.too_long   = {1'b0, len_q} > 9'(PARAM_DEPTH + 2);
    status_o.param_done = idx_plus3 >= {1'b0, len_q};
    status_o.frame_ok   = (rx_byte_i == ~sum_q) && (cmd_cls != sbpp_pkg::CMD_NONE);
    status_o.has_params = (count_d != '0);
    status_o.emit_last  = (rd_idx_next == out_count_q);
    status_o.out_valid  = out_valid_q;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // frame registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load_id) begin
      idx_q <= '0;
    end else if (cmd_i.store_param) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_id) begin
      target_q <= rx_byte_i;
      sum_q    <= rx_byte_i;
    end
    if (cmd_i.load_len) begin
      len_q <= rx_byte_i;
      sum_q <= sum_q + rx_byte_i;
    end
    if (cmd_i.load_instr) begin
      instr_q <= rx_byte_i;
      sum_q   <= sum_q + rx_byte_i;
    end
    if (cmd_i.store_param) begin
      sum_q <= sum_q + rx_byte_i;
    end
  end

  assign ram_re    = cmd_i.emit_hdr || (cmd_i.emit_next && !status_o.emit_last);
  assign ram_raddr = cmd_i.emit_hdr ? '0 : rd_addr_next;

  sbpp_ram #(
    .WIDTH (8),
    .DEPTH (PARAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_param),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_hdr || cmd_i.emit_next) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hdr) begin
      out_kind_q  <= 1'b0;
      out_cmd_q   <= cmd_cls;
      out_self_q  <= self_d;
      out_reply_q <= reply_d;
      out_count_q <= count_d;
      out_byte_q  <= 8'd0;
      out_last_q  <= (count_d == '0);
      rd_idx_q    <= '0;
    end else if (cmd_i.emit_next) begin
      out_kind_q <= 1'b1;
      out_byte_q <= ram_rdata;
      out_last_q <= status_o.emit_last;
      rd_idx_q   <= rd_idx_next;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign command_o           = out_cmd_q;
  assign addressed_to_self_o = out_self_q;
  assign send_reply_o        = out_reply_q;
  assign param_count_o       = 6'(out_count_q);
  assign param_byte_o        = out_byte_q;
  assign last_o              = out_last_q;

`ifndef NO_ASSERTIONS
  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_param |-> (32'(idx_q) < PARAM_DEPTH))
    else $error("parameter write beyond store");

  a_emit_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_next |-> (out_valid_q && (rd_idx_q < out_count_q)))
    else $error("parameter transfer beyond count");

  a_param_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q) |-> (out_count_q != '0))
    else $error("parameter result with zero count");

  a_hdr_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_hdr |=> (out_valid_q && !out_kind_q))
    else $error("command result not loaded");
`endif

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_SYNC0,
    PH_SYNC1,
    PH_ID,
    PH_LEN,
    PH_INSTR,
    PH_PARAM,
    PH_CSUM
  } parse_phase_e;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic             kind;
    sbpp_pkg::cmd_e   cmd;
    logic             to_self;
    logic             reply;
    logic [5:0]       count;
    logic [7:0]       pbyte;
    logic             last;
  } parse_result_t;

  localparam int unsigned IDLE_PAUSE  = 40;
  localparam int unsigned DRAIN_LIMIT = 5000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [sbpp_pkg::REG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata      = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        result_kind_o;
  logic [2:0]  command_o;
  logic        addressed_to_self_o;
  logic        send_reply_o;
  logic [5:0]  param_count_o;
  logic [7:0]  param_byte_o;
  logic        last_o;
  logic [31:0] prdata;
  logic        pready;

  servo_bus_packet_parser uut (.*);

  // parser mirror
  logic [7:0]   cfg_own_id   = sbpp_pkg::RST_OWN_ID;
  logic [7:0]   cfg_reply_op = sbpp_pkg::RST_REPLY_OP;
  logic [7:0]   cfg_calib_op = sbpp_pkg::RST_CALIB_OP;
  parse_phase_e parse_phase  = PH_SYNC0;
  logic [7:0]   frame_id     = 8'h00;
  logic [7:0]   frame_len    = 8'h00;
  logic [7:0]   frame_op     = 8'h00;
  logic [7:0]   frame_sum    = 8'h00;
  logic [5:0]   param_fill   = 6'd0;
  logic [7:0]   param_mem [sbpp_pkg::SBPP_PARAM_DEPTH];

  logic [7:0]    pending_bytes[$];
  parse_result_t cmd_results_due[$];
  int unsigned   queued_count  = 0;
  int unsigned   taken_count   = 0;
  int unsigned   fail_count    = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct     = 0;
  bit            byte_taken    = 1'b0;

  always #10 clk_i = ~clk_i;

  function automatic void clear_frame();
    parse_phase = PH_SYNC0;
    frame_id    = 8'h00;
    frame_len   = 8'h00;
    frame_op    = 8'h00;
    frame_sum   = 8'h00;
    param_fill  = 6'd0;
  endfunction

  function automatic bit no_param_op(input logic [7:0] op);
    return op == cfg_calib_op || op == sbpp_pkg::OP_PING || op == sbpp_pkg::OP_ACTION ||
           op == sbpp_pkg::OP_RESET;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] c);
    int unsigned    need;
    sbpp_pkg::cmd_e cmd;
    logic [5:0]     cnt;
    logic           to_self;
    parse_result_t  r;
    case (parse_phase)
      PH_SYNC0: begin
        if (c == sbpp_pkg::START_BYTE) parse_phase = PH_SYNC1;
        else clear_frame();
      end
      PH_SYNC1: begin
        if (c == sbpp_pkg::START_BYTE) parse_phase = PH_ID;
        else clear_frame();
      end
      PH_ID: begin
        if (c == cfg_own_id || c == sbpp_pkg::BROADCAST_ID) begin
          frame_id    = c;
          frame_sum   = c;
          parse_phase = PH_LEN;
        end else begin
          clear_frame();
        end
      end
      PH_LEN: begin
        frame_sum   = frame_sum + c;
        frame_len   = c;
        parse_phase = PH_INSTR;
      end
      PH_INSTR: begin
        frame_sum = frame_sum + c;
        frame_op  = c;
        need = (frame_len <= 8'd2) ? 1 : int'(frame_len) - 2;
        if (no_param_op(c)) parse_phase = PH_CSUM;
        else if (c == cfg_reply_op || need > sbpp_pkg::SBPP_PARAM_DEPTH) clear_frame();
        else parse_phase = PH_PARAM;
      end
      PH_PARAM: begin
        frame_sum = frame_sum + c;
        param_mem[param_fill] = c;
        param_fill = param_fill + 6'd1;
        if (int'(param_fill) + 2 >= int'(frame_len)) parse_phase = PH_CSUM;
      end
      PH_CSUM: begin
        case (frame_op)
          sbpp_pkg::OP_PING:      cmd = sbpp_pkg::CMD_PING;
          sbpp_pkg::OP_ACTION:    cmd = sbpp_pkg::CMD_ACTION;
          sbpp_pkg::OP_READ:      cmd = sbpp_pkg::CMD_READ;
          sbpp_pkg::OP_WRITE:     cmd = sbpp_pkg::CMD_WRITE;
          sbpp_pkg::OP_REG_WRITE: cmd = sbpp_pkg::CMD_REG_WRITE;
          sbpp_pkg::OP_RESET:     cmd = sbpp_pkg::CMD_RESET;
          default: begin
            cmd = (frame_op == cfg_calib_op) ? sbpp_pkg::CMD_CALIBRATE : sbpp_pkg::CMD_NONE;
          end
        endcase
        if (c == ~frame_sum && cmd != sbpp_pkg::CMD_NONE) begin
          cnt = (cmd == sbpp_pkg::CMD_READ || cmd == sbpp_pkg::CMD_WRITE ||
                 cmd == sbpp_pkg::CMD_REG_WRITE) ? param_fill : 6'd0;
          to_self = (frame_id == cfg_own_id);
          for (int k = 0; k <= int'(cnt); k++) begin
            r.kind    = (k != 0);
            r.cmd     = cmd;
            r.to_self = to_self;
            r.reply   = to_self && (cmd == sbpp_pkg::CMD_PING ||
                                    cmd == sbpp_pkg::CMD_REG_WRITE ||
                                    cmd == sbpp_pkg::CMD_RESET);
            r.count   = cnt;
            r.pbyte   = (k == 0) ? 8'h00 : param_mem[k-1];
            r.last    = (k == int'(cnt));
            cmd_results_due.push_back(r);
          end
        end
        clear_frame();
      end
      default: clear_frame();
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // monitor: result transfers are checked before the byte of the same edge is parsed
  always @(posedge clk_i) begin
    parse_result_t want;
    byte_taken = 1'b0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cmd_results_due.size() == 0) begin
        $error("unexpected result transfer: kind %0d command %0d", result_kind_o, command_o);
        fail_count++;
      end else begin
        want = cmd_results_due.pop_front();
        check_field("result_kind", want.kind, result_kind_o);
        check_field("command", want.cmd, command_o);
        check_field("addressed_to_self", want.to_self, addressed_to_self_o);
        check_field("send_reply", want.reply, send_reply_o);
        check_field("param_count", want.count, param_count_o);
        check_field("param_byte", want.pbyte, param_byte_o);
        check_field("last", want.last, last_o);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      byte_taken = 1'b1;
      taken_count++;
      parse_rx_byte(rx_byte_i);
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!in_valid_i || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h000000, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== val) begin
      $error("prdata mismatch at register %0d: expected %0h, got %0h", idx, val, prdata[7:0]);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      sbpp_pkg::REG_OWN_ID:   cfg_own_id   = val;
      sbpp_pkg::REG_REPLY_OP: cfg_reply_op = val;
      default:                cfg_calib_op = val;
    endcase
  endtask

  function automatic void send_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_count++;
  endfunction

  function automatic void add_packet(input logic [7:0] id, input logic [7:0] len,
                                     input logic [7:0] instr, input int unsigned nparams,
                                     input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    send_byte(sbpp_pkg::START_BYTE);
    send_byte(sbpp_pkg::START_BYTE);
    send_byte(id);
    send_byte(len);
    send_byte(instr);
    sum = id + len + instr;
    for (int i = 0; i < int'(nparams); i++) begin
      if ($urandom_range(99) < 10) b = 8'hFF;
      else if ($urandom_range(99) < 10) b = 8'h00;
      else b = 8'($urandom_range(255));
      send_byte(b);
      sum = sum + b;
    end
    sum = ~sum;
    if (corrupt) sum = sum ^ (8'h01 << $urandom_range(7));
    send_byte(sum);
  endfunction

  function automatic void add_random_packet();
    int unsigned sel;
    int unsigned nparams;
    logic [7:0]  id;
    logic [7:0]  len;
    logic [7:0]  instr;
    sel = $urandom_range(99);
    if (sel < 45) id = cfg_own_id;
    else if (sel < 80) id = sbpp_pkg::BROADCAST_ID;
    else id = 8'($urandom_range(255));
    sel = $urandom_range(99);
    if (sel < 12) instr = sbpp_pkg::OP_PING;
    else if (sel < 20) instr = sbpp_pkg::OP_ACTION;
    else if (sel < 35) instr = sbpp_pkg::OP_READ;
    else if (sel < 52) instr = sbpp_pkg::OP_WRITE;
    else if (sel < 67) instr = sbpp_pkg::OP_REG_WRITE;
    else if (sel < 75) instr = sbpp_pkg::OP_RESET;
    else if (sel < 83) instr = cfg_calib_op;
    else if (sel < 89) instr = cfg_reply_op;
    else instr = 8'($urandom_range(255));
    if (no_param_op(instr)) begin
      len = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'd2;
      nparams = 0;
    end else begin
      sel = $urandom_range(99);
      if (sel < 70) len = 8'($urandom_range(8));
      else if (sel < 88) len = 8'($urandom_range(34, 9));
      else len = 8'($urandom_range(255, 35));
      if (len > 8'd34) nparams = $urandom_range(3);
      else if (len <= 8'd2) nparams = 1;
      else nparams = int'(len) - 2;
    end
    add_packet(id, len, instr, nparams, $urandom_range(99) < 12);
  endfunction

  function automatic void add_noise();
    int unsigned n;
    n = $urandom_range(6, 1);
    repeat (n) begin
      send_byte(($urandom_range(99) < 35) ? sbpp_pkg::START_BYTE : 8'($urandom_range(255)));
    end
  endfunction

  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    while (taken_count != queued_count) @(negedge clk_i);
    while (cmd_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (cmd_results_due.size() != 0) begin
      $error("%0d expected results never arrived", cmd_results_due.size());
      fail_count++;
      cmd_results_due.delete();
    end
    repeat (IDLE_PAUSE) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] own, input logic [7:0] reply,
                           input logic [7:0] calib, input idle_mode_e mode,
                           input int unsigned nbytes);
    int unsigned first;
    write_reg(sbpp_pkg::REG_OWN_ID, own);
    write_reg(sbpp_pkg::REG_REPLY_OP, reply);
    write_reg(sbpp_pkg::REG_CALIB_OP, calib);
    send_idle_pct = (mode == IDLE_SENDER) ? 66 : (mode == IDLE_BOTH) ? 9 : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? 66 : (mode == IDLE_BOTH) ? 9 : 0;
    @(posedge clk_i);
    first = queued_count;
    while (queued_count - first < nbytes) begin
      if ($urandom_range(99) < 85) add_random_packet();
      else add_noise();
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed packets with register reset values
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd2, sbpp_pkg::OP_PING, 0, 1'b0);
    add_packet(sbpp_pkg::BROADCAST_ID, 8'd2, sbpp_pkg::OP_ACTION, 0, 1'b0);
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd4, sbpp_pkg::OP_READ, 2, 1'b0);
    add_packet(sbpp_pkg::BROADCAST_ID, 8'd3, sbpp_pkg::OP_WRITE, 1, 1'b0);
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd34, sbpp_pkg::OP_REG_WRITE, 32, 1'b0);
    add_packet(sbpp_pkg::BROADCAST_ID, 8'd6, sbpp_pkg::OP_REG_WRITE, 4, 1'b0);
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd2, sbpp_pkg::OP_RESET, 0, 1'b0);
    add_packet(sbpp_pkg::BROADCAST_ID, 8'd2, sbpp_pkg::RST_CALIB_OP, 0, 1'b0);
    // short length still stores one parameter
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd0, sbpp_pkg::OP_WRITE, 1, 1'b0);
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd2, sbpp_pkg::OP_READ, 1, 1'b0);
    // too long for the store, rest parsed as header bytes
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd35, sbpp_pkg::OP_READ, 0, 1'b0);
    add_packet(sbpp_pkg::BROADCAST_ID, 8'd255, sbpp_pkg::OP_WRITE, 0, 1'b0);
    add_packet(sbpp_pkg::BROADCAST_ID, 8'd3, 8'h40, 1, 1'b0);
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd3, sbpp_pkg::RST_REPLY_OP, 1, 1'b0);
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd2, sbpp_pkg::OP_PING, 0, 1'b1);
    add_packet(8'h05, 8'd2, sbpp_pkg::OP_PING, 0, 1'b0);
    send_byte(sbpp_pkg::START_BYTE);
    send_byte(8'h00);
    add_packet(sbpp_pkg::BROADCAST_ID, 8'd2, sbpp_pkg::OP_PING, 0, 1'b0);
    add_packet(sbpp_pkg::RST_OWN_ID, 8'd5, sbpp_pkg::OP_RESET, 0, 1'b0);
    wait_idle();

    run_phase(8'd253, 8'hFF, 8'h00, IDLE_NONE, 30);
    run_phase(8'd0, sbpp_pkg::OP_READ, 8'hFF, IDLE_SENDER, 30);
    run_phase(8'($urandom_range(253)), 8'h00, sbpp_pkg::OP_WRITE, IDLE_RECEIVER, 30);
    run_phase(8'($urandom_range(253)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              IDLE_BOTH, 30);
    run_phase(sbpp_pkg::RST_OWN_ID, sbpp_pkg::OP_RESET, sbpp_pkg::OP_PING, IDLE_NONE, 30);
    run_phase(8'($urandom_range(253)), 8'($urandom_range(255)), sbpp_pkg::RST_CALIB_OP,
              IDLE_RECEIVER, 30);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
